FILE: sv/sref_pkg.sv
// Package for the spike-rejecting smoothing filter.
// Holds the field types, status and register codes, and the decision record.
// No dependencies; every other file of the block refers to it by scoped names.
package sref_pkg;

  typedef logic [1:0]        chan_t;
  typedef logic signed [15:0] sample_t;
  typedef logic [15:0]       limit_t;
  typedef logic [1:0]        status_t;
  typedef logic [1:0]        count_t;
  typedef logic [1:0]        reg_idx_t;

  // Status codes carried with each result.
  localparam status_t ST_FIRST  = 2'd0;
  localparam status_t ST_HELD   = 2'd1;
  localparam status_t ST_STEP   = 2'd2;
  localparam status_t ST_SMOOTH = 2'd3;

  // Configuration register indexes.
  localparam reg_idx_t REG_LIMIT_A = 2'd0;
  localparam reg_idx_t REG_LIMIT_B = 2'd1;
  localparam reg_idx_t REG_LIMIT_C = 2'd2;
  localparam reg_idx_t REG_LIMIT_D = 2'd3;

  localparam int NUM_REGS = 4;

  localparam limit_t LIMIT_A_RST = 16'd320;
  localparam limit_t LIMIT_B_RST = 16'd480;
  localparam limit_t LIMIT_C_RST = 16'd32;
  localparam limit_t LIMIT_D_RST = 16'd80;

  // Outcome of one sample: the result and the new state of its channel.
  typedef struct packed {
    sample_t filtered;
    status_t status;
    logic    upd;
    sample_t past_nxt;
    count_t  count_nxt;
  } decide_t;

endpackage

FILE: sv/sref_if.sv
// Valid/ready channel interfaces for the filter's samples and results.
// Depends on sref_pkg for the field types.
interface sref_in_if;
  logic              valid;
  logic              ready;
  sref_pkg::chan_t   channel;
  sref_pkg::sample_t sample;

  modport source (output valid, output channel, output sample, input ready);
  modport sink   (input valid, input channel, input sample, output ready);
endinterface

interface sref_out_if;
  logic              valid;
  logic              ready;
  sref_pkg::chan_t   out_channel;
  sref_pkg::sample_t filtered;
  sref_pkg::status_t status;

  modport source (output valid, output out_channel, output filtered, output status,
                  input ready);
  modport sink   (input valid, input out_channel, input filtered, input status,
                  output ready);
endinterface

FILE: sv/sref_decide.sv
// Per-sample decision of the filter: spike test, hold counting and halving.
// Purely combinational; depends on sref_pkg for types and status codes.
module sref_decide #(
  parameter int HOLD_LIMIT = 3
) (
  input  logic              in_range,
  input  logic              primed,
  input  sref_pkg::sample_t sample,
  input  sref_pkg::sample_t past,
  input  sref_pkg::count_t  count,
  input  sref_pkg::limit_t  limit,
  output sref_pkg::decide_t dec
);

  logic signed [16:0] diff;
  logic        [16:0] adiff;
  logic signed [16:0] sum;

  always_comb begin
    diff  = {sample[15], sample} - {past[15], past};
    adiff = diff[16] ? 17'(-diff) : 17'(diff);
    sum   = {sample[15], sample} + {past[15], past};

    dec.filtered  = sample;
    dec.status    = sref_pkg::ST_FIRST;
    dec.upd       = 1'b0;
    dec.past_nxt  = past;
    dec.count_nxt = count;

    if (!in_range) begin
      // Unknown channel: pass through and leave every channel alone.
      dec.upd = 1'b0;
    end else if (!primed) begin
      dec.upd       = 1'b1;
      dec.past_nxt  = sample;
      dec.count_nxt = '0;
    end else if (adiff >= {1'b0, limit}) begin
      dec.upd = 1'b1;
      if (count < 2'(HOLD_LIMIT)) begin
        dec.count_nxt = count + 2'd1;
        dec.filtered  = past;
        dec.status    = sref_pkg::ST_HELD;
      end else begin
        dec.count_nxt = '0;
        dec.past_nxt  = sample;
        dec.status    = sref_pkg::ST_STEP;
      end
    end else begin
      // An arithmetic halving of the 17-bit sum floors towards minus infinity.
      dec.upd       = 1'b1;
      dec.count_nxt = '0;
      dec.past_nxt  = sum[16:1];
      dec.filtered  = sum[16:1];
      dec.status    = sref_pkg::ST_SMOOTH;
    end
  end

endmodule

FILE: sv/spike_reject_ema_filter.sv
// Top level of the spike-rejecting smoothing filter for signed Q11.4 samples.
// Depends on sref_pkg, the interfaces in sref_if.sv and sref_decide.
//
// Usage:
//   Samples arrive on in_if (channel, sample) and one result per sample leaves
//   on out_if (out_channel, filtered, status); a transaction completes on an
//   edge where valid and ready are both high. Spike limits are written through
//   cfg_we / cfg_index / cfg_wdata while no sample is in flight.
//   A sample goes into an input register; the channel state is then read and
//   updated and the result is written into the output register, which drives
//   out_if.valid and the result until the receiver takes them.
//   Throughput is one sample per cycle while out_if.ready stays high, also on
//   the same channel back to back, since a channel's state is read, updated and
//   written back in the same cycle as its result enters the output register.
//   When the receiver stalls, the result waits in the output register and one
//   more sample may be taken into the input register before in_if.ready falls.
//   Reset clears the pipeline, every channel's primed flag and spike count, and
//   loads the default limits; the block accepts samples the cycle after reset.
module spike_reject_ema_filter #(
  parameter int CHANNELS   = 4,
  parameter int HOLD_LIMIT = 3
) (
  input  logic                 clk,
  input  logic                 rst_n,
  sref_in_if.sink              in_if,
  sref_out_if.source           out_if,
  input  logic                 cfg_we,
  input  sref_pkg::reg_idx_t   cfg_index,
  input  sref_pkg::limit_t     cfg_wdata
);

  // Input register.
  logic              s1_valid_r;
  sref_pkg::chan_t   s1_ch_r;
  sref_pkg::sample_t s1_x_r;

  // Output register.
  logic              out_valid_r;
  sref_pkg::chan_t   out_ch_r;
  sref_pkg::sample_t out_y_r;
  sref_pkg::status_t out_st_r;

  // Configuration and channel state.
  sref_pkg::limit_t  limit_r [sref_pkg::NUM_REGS];
  sref_pkg::sample_t past_r  [CHANNELS];
  sref_pkg::count_t  count_r [CHANNELS];
  logic [CHANNELS-1:0] primed_r;

  logic                out_adv;
  logic                s1_fire;
  logic                in_fire;
  logic [CHANNELS-1:0] sel_oh;
  logic                in_range;
  logic                cur_primed;
  sref_pkg::sample_t   cur_past;
  sref_pkg::count_t    cur_count;
  sref_pkg::decide_t   dec;

  assign out_adv   = !out_valid_r || out_if.ready;
  assign s1_fire   = s1_valid_r && out_adv;
  assign in_if.ready = !s1_valid_r || out_adv;
  assign in_fire   = in_if.valid && in_if.ready;

  always_comb begin
    cur_past   = '0;
    cur_count  = '0;
    cur_primed = 1'b0;
    for (int i = 0; i < CHANNELS; i++) begin
      sel_oh[i] = (s1_ch_r == 2'(i));
      if (sel_oh[i]) begin
        cur_past   = past_r[i];
        cur_count  = count_r[i];
        cur_primed = primed_r[i];
      end
    end
    in_range = |sel_oh;
  end

  sref_decide #(
    .HOLD_LIMIT (HOLD_LIMIT)
  ) u_decide (
    .in_range (in_range),
    .primed   (cur_primed),
    .sample   (s1_x_r),
    .past     (cur_past),
    .count    (cur_count),
    .limit    (limit_r[s1_ch_r]),
    .dec      (dec)
  );

  // Pipeline control.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_if.ready) begin
        s1_valid_r <= in_if.valid;
      end
      if (out_adv) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  // Pipeline payload.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_ch_r <= in_if.channel;
      s1_x_r  <= in_if.sample;
    end
    if (s1_fire) begin
      out_ch_r <= s1_ch_r;
      out_y_r  <= dec.filtered;
      out_st_r <= dec.status;
    end
  end

  // Limit registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r[sref_pkg::REG_LIMIT_A] <= sref_pkg::LIMIT_A_RST;
      limit_r[sref_pkg::REG_LIMIT_B] <= sref_pkg::LIMIT_B_RST;
      limit_r[sref_pkg::REG_LIMIT_C] <= sref_pkg::LIMIT_C_RST;
      limit_r[sref_pkg::REG_LIMIT_D] <= sref_pkg::LIMIT_D_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        sref_pkg::REG_LIMIT_A: limit_r[sref_pkg::REG_LIMIT_A] <= cfg_wdata;
        sref_pkg::REG_LIMIT_B: limit_r[sref_pkg::REG_LIMIT_B] <= cfg_wdata;
        sref_pkg::REG_LIMIT_C: limit_r[sref_pkg::REG_LIMIT_C] <= cfg_wdata;
        sref_pkg::REG_LIMIT_D: limit_r[sref_pkg::REG_LIMIT_D] <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Channel control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      primed_r <= '0;
      for (int i = 0; i < CHANNELS; i++) begin
        count_r[i] <= '0;
      end
    end else if (s1_fire && dec.upd) begin
      for (int i = 0; i < CHANNELS; i++) begin
        if (sel_oh[i]) begin
          primed_r[i] <= 1'b1;
          count_r[i]  <= dec.count_nxt;
        end
      end
    end
  end

  // Past values are only read once their channel is primed.
  always_ff @(posedge clk) begin
    if (s1_fire && dec.upd) begin
      for (int i = 0; i < CHANNELS; i++) begin
        if (sel_oh[i]) begin
          past_r[i] <= dec.past_nxt;
        end
      end
    end
  end

  assign out_if.valid       = out_valid_r;
  assign out_if.out_channel = out_ch_r;
  assign out_if.filtered    = out_y_r;
  assign out_if.status      = out_st_r;

  a_sel_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(sel_oh))
    else $error("channel select is not one-hot");

  a_ready_low_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_if.ready |-> (s1_valid_r && out_valid_r))
    else $error("input stalled while a pipeline register is free");

  a_primed_after: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire |=> ((primed_r & $past(sel_oh)) == $past(sel_oh)))
    else $error("channel not primed after its transaction");

  a_held_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_fire && dec.status == sref_pkg::ST_HELD) |-> (cur_count < 2'(HOLD_LIMIT)))
    else $error("sample held beyond the hold limit");

endmodule
